>>> sv/fitch_parsimony_combine_top_assert.svh
// assertion macros for the fitch parsimony combine block
`ifndef FITCH_PARSIMONY_COMBINE_TOP_ASSERT_SVH
`define FITCH_PARSIMONY_COMBINE_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define FPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("fpc assertion failed");

// next-cycle implication, checked out of reset
`define FPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("fpc assertion failed");

`else

`define FPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)

`define FPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

>>> sv/fpc_pkg.sv
// shared types and constants for the fitch parsimony combine block
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  // geometry of one item
  localparam int LANES      = 4;
  localparam int SET_W      = 4;
  localparam int SCORE_W    = 32;
  localparam int COST_W     = 3;
  localparam int STATES_DEF = 4;

  // input item: two child sets per lane, child scores, last flag
  typedef struct packed {
    logic [SET_W-1:0]   left_set_0;
    logic [SET_W-1:0]   left_set_1;
    logic [SET_W-1:0]   left_set_2;
    logic [SET_W-1:0]   left_set_3;
    logic [SET_W-1:0]   right_set_0;
    logic [SET_W-1:0]   right_set_1;
    logic [SET_W-1:0]   right_set_2;
    logic [SET_W-1:0]   right_set_3;
    logic [SCORE_W-1:0] left_subtree_score;
    logic [SCORE_W-1:0] right_subtree_score;
    logic               last_group;
  } in_item_t;

  // result item: parent sets, lane cost, node score on the last group
  typedef struct packed {
    logic [SET_W-1:0]   parent_set_0;
    logic [SET_W-1:0]   parent_set_1;
    logic [SET_W-1:0]   parent_set_2;
    logic [SET_W-1:0]   parent_set_3;
    logic [COST_W-1:0]  group_cost;
    logic [SCORE_W-1:0] node_score;
    logic               done_res;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/fitch_parsimony_combine_top.sv
// top level of the fitch parsimony combine block
//
//  channel  | ports                          | direction | payload
//  ---------+--------------------------------+-----------+---------------------
//  input    | in_valid, in_ready, in_item    | in        | fpc_pkg::in_item_t
//  result   | out_valid, out_ready, out_item | out       | fpc_pkg::out_item_t
//
// one item per cycle sustained while out_ready holds; an item passes through the input
// register and then the result register, which drives out_valid and out_item.
// the set logic, lane cost count and saturating score adds sit between them.
// rst_n is synchronous and clears the valid flags and the run cost register.
// a stalled result holds its register; the input register keeps accepting
// while it is empty or moving into the result register.
`timescale 1ns / 1ps
`default_nettype none

`include "fitch_parsimony_combine_top_assert.svh"

module fitch_parsimony_combine_top #(
  parameter int STATES = fpc_pkg::STATES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output fpc_pkg::out_item_t      out_item
  ,input wire logic               out_ready
);

  localparam int SW        = fpc_pkg::SET_W;
  localparam int NL        = fpc_pkg::LANES;
  localparam int SCW       = fpc_pkg::SCORE_W;
  localparam int CW        = fpc_pkg::COST_W;
  localparam int MASK_BITS = (STATES < SW) ? STATES : SW;
  localparam logic [SW-1:0] STATE_MASK = {SW{1'b1}} >> (SW - MASK_BITS);

  // input register
  logic                s1_v_r;
  fpc_pkg::in_item_t   s1_item_r;
  logic [SCW:0]        s1_child_sum_r;

  // result register and run cost
  logic                out_v_r;
  fpc_pkg::out_item_t  out_item_r;
  fpc_pkg::out_item_t  out_item_nxt;
  logic [SCW-1:0]      cost_total_r;
  logic [SCW-1:0]      cost_total_nxt;

  logic                adv;
  logic [SW-1:0]       lset   [NL];
  logic [SW-1:0]       rset   [NL];
  logic [SW-1:0]       parent [NL];
  logic [NL-1:0]       lane_cost;
  logic [CW-1:0]       cost;
  logic [SCW:0]        run_sum;
  logic [SCW-1:0]      run;
  logic [SCW+1:0]      score_sum;

  // handshake: result register frees up when empty or taken
  assign adv       = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || adv;
  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // input register, with child score sum formed early
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item_r      <= in_item;
      s1_child_sum_r <= {1'b0, in_item.left_subtree_score}
                      + {1'b0, in_item.right_subtree_score};
    end
  end

  // lane view of the masked child sets
  always_comb begin
    lset[0] = s1_item_r.left_set_0  & STATE_MASK;
    lset[1] = s1_item_r.left_set_1  & STATE_MASK;
    lset[2] = s1_item_r.left_set_2  & STATE_MASK;
    lset[3] = s1_item_r.left_set_3  & STATE_MASK;
    rset[0] = s1_item_r.right_set_0 & STATE_MASK;
    rset[1] = s1_item_r.right_set_1 & STATE_MASK;
    rset[2] = s1_item_r.right_set_2 & STATE_MASK;
    rset[3] = s1_item_r.right_set_3 & STATE_MASK;
  end

  // per lane: intersection, or union at a cost of one when disjoint
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if ((lset[i] & rset[i]) != '0) begin
        parent[i]    = lset[i] & rset[i];
        lane_cost[i] = 1'b0;
      end else begin
        parent[i]    = lset[i] | rset[i];
        lane_cost[i] = 1'b1;
      end
    end
  end

  // lane cost count and saturating run and node scores
  always_comb begin
    cost = '0;
    for (int i = 0; i < NL; i++) begin
      cost = cost + CW'(lane_cost[i]);
    end
    run_sum   = {1'b0, cost_total_r} + (SCW + 1)'(cost);
    run       = run_sum[SCW] ? {SCW{1'b1}} : run_sum[SCW-1:0];
    score_sum = {2'b00, run} + {1'b0, s1_child_sum_r};

    out_item_nxt.parent_set_0 = parent[0];
    out_item_nxt.parent_set_1 = parent[1];
    out_item_nxt.parent_set_2 = parent[2];
    out_item_nxt.parent_set_3 = parent[3];
    out_item_nxt.group_cost   = cost;
    out_item_nxt.done_res     = s1_item_r.last_group;
    if (s1_item_r.last_group) begin
      out_item_nxt.node_score = (score_sum[SCW+1:SCW] != 2'b00) ? {SCW{1'b1}}
                                                                : score_sum[SCW-1:0];
      cost_total_nxt          = '0;
    end else begin
      out_item_nxt.node_score = '0;
      cost_total_nxt          = run;
    end
  end

  // result register and run cost accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      cost_total_r <= '0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
      if (s1_v_r) begin
        cost_total_r <= cost_total_nxt;
      end
    end
    if (adv && s1_v_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // checks
  `FPC_ASSERT_IMP(a_cost_range, clk, rst_n, out_v_r, out_item_r.group_cost <= CW'(NL))
  `FPC_ASSERT_IMP(a_score_zero, clk, rst_n, out_v_r && !out_item_r.done_res, out_item_r.node_score == '0)
  `FPC_ASSERT_NXT(a_run_clear, clk, rst_n, adv && s1_v_r && s1_item_r.last_group, cost_total_r == '0)

endmodule

`default_nettype wire
